[rtl/remote_start_sequencer_assert.svh]
// assertion macros used by the sequencer back end (rss_back)
`ifndef REMOTE_START_SEQUENCER_ASSERT_SVH
`define REMOTE_START_SEQUENCER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define RSS_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("remote_start_sequencer assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("remote_start_sequencer assertion failed");

`endif

[rtl/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg
// types, codes and helpers shared by the remote start sequencer modules
// ----------------------------------------------------------------------------
package rss_pkg;

   localparam int MAX_ACTS = 5;
   localparam int CNT_W    = 3;
   localparam int DUR_W    = 20;
   localparam int RPM_W    = 14;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int Q_DEPTH  = 2;

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_STOP   = 3'd1,
      OP_UPDATE = 3'd2,
      OP_TIMER  = 3'd3,
      OP_INFRA  = 3'd4,
      OP_RESET  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_AUTH     = 3'd1,
      ST_PREP     = 3'd2,
      ST_CRANK    = 3'd3,
      ST_RUN      = 3'd4,
      ST_STOPPING = 3'd5,
      ST_FAULT    = 3'd6
   } ctrl_state_type;

   typedef enum logic [3:0] {
      F_NONE          = 4'd0,
      F_INTERLOCK     = 4'd1,
      F_VEHICLE_COMM  = 4'd2,
      F_AUTH_TIMEOUT  = 4'd3,
      F_CRANK_TIMEOUT = 4'd4,
      F_STOP_TIMEOUT  = 4'd5,
      F_ACTUATOR      = 4'd6,
      F_TIMER         = 4'd7,
      F_INTERNAL      = 4'd8
   } fault_type;

   typedef enum logic [4:0] {
      A_NONE        = 5'd0,
      A_REQ_VEHICLE = 5'd1,
      A_IGNITION    = 5'd2,
      A_ENGAGE      = 5'd3,
      A_DISENGAGE   = 5'd4,
      A_SECURE      = 5'd5,
      A_ARM         = 5'd6,
      A_CANCEL      = 5'd7,
      A_PROFILE_REJ = 5'd8,
      A_START_ACC   = 5'd9,
      A_START_REJ   = 5'd10,
      A_RUNNING     = 5'd11,
      A_STOPPING    = 5'd12,
      A_STOPPED     = 5'd13,
      A_FAULT       = 5'd14,
      A_READY       = 5'd15,
      A_IGNORED     = 5'd16,
      A_RESET_REJ   = 5'd17
   } action_type;

   // register indexes on the configuration port
   typedef enum logic [2:0] {
      R_AUTH_TIMEOUT = 3'd0,
      R_PREP_DELAY   = 3'd1,
      R_CRANK_LIMIT  = 3'd2,
      R_RUN_LIMIT    = 3'd3,
      R_STOP_CONFIRM = 3'd4,
      R_RPM_LEVEL    = 3'd5,
      R_PROFILE      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [3:0]       event_fault;
      logic             rpm_fresh;
      logic [RPM_W-1:0] engine_rpm;
      logic             crit_fault_fresh;
      logic             crit_fault_present;
      logic             start_safe;
      logic             crank_safe;
      logic             run_safe;
   } req_type;

   typedef struct packed {
      logic [4:0]       action;
      logic [DUR_W-1:0] duration_ms;
      logic [2:0]       prior_state;
      logic [2:0]       new_state;
      logic [3:0]       fault_now;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0] authorize_timeout_ms;
      logic [DUR_W-1:0] prepare_delay_ms;
      logic [DUR_W-1:0] crank_limit_ms;
      logic [DUR_W-1:0] run_limit_ms;
      logic [DUR_W-1:0] stop_confirm_ms;
      logic [RPM_W-1:0] running_rpm_level;
      logic             profile_ready;
   } cfg_type;

   typedef action_type [MAX_ACTS-1:0] act_list_type;

   // one classified event: its actions and the state it leaves
   typedef struct packed {
      act_list_type     acts;
      logic [CNT_W-1:0] count;
      logic [DUR_W-1:0] dur;
      ctrl_state_type   prior;
      ctrl_state_type   nxt;
      fault_type        fault;
   } plan_type;

   function automatic act_list_type act_list(input action_type a0, input action_type a1,
                                             input action_type a2, input action_type a3,
                                             input action_type a4);
      act_list_type l;
      l[0] = a0;
      l[1] = a1;
      l[2] = a2;
      l[3] = a3;
      l[4] = a4;
      return l;
   endfunction

endpackage

[rtl/rss_front.sv]
// ----------------------------------------------------------------------------
// rss_front
// accepts events, steps the controller state and emits one plan per event
// ----------------------------------------------------------------------------
module rss_front (
   input  logic             clock,
   input  logic             reset,
   input  rss_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  rss_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output rss_pkg::plan_type plan
);

   rss_pkg::ctrl_state_type state_ff, state_in;
   rss_pkg::fault_type      fault_ff, fault_in;
   logic eng, rpm_low, crit_clear;
   rss_pkg::fault_type infra_fault;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   assign eng        = req_data.rpm_fresh && (req_data.engine_rpm >= cfg.running_rpm_level);
   assign rpm_low    = req_data.rpm_fresh && !eng;
   assign crit_clear = req_data.crit_fault_fresh && !req_data.crit_fault_present;
   assign infra_fault = (req_data.event_fault == rss_pkg::F_NONE ||
                         req_data.event_fault > rss_pkg::F_INTERNAL) ?
                        rss_pkg::F_INTERNAL : rss_pkg::fault_type'(req_data.event_fault);

   always_comb begin
      rss_pkg::act_list_type fault_seq, stopped_seq, stopping_seq;
      logic to_fault;
      logic to_stopped;
      logic to_stopping;
      rss_pkg::fault_type new_fault;
      fault_seq    = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_DISENGAGE,
                        rss_pkg::A_SECURE, rss_pkg::A_FAULT, rss_pkg::A_NONE);
      stopped_seq  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_DISENGAGE,
                        rss_pkg::A_SECURE, rss_pkg::A_STOPPED, rss_pkg::A_NONE);
      stopping_seq = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_DISENGAGE,
                        rss_pkg::A_SECURE, rss_pkg::A_STOPPING, rss_pkg::A_ARM);
      to_fault    = 1'b0;
      to_stopped  = 1'b0;
      to_stopping = 1'b0;
      new_fault   = rss_pkg::F_INTERLOCK;
      state_in    = state_ff;
      fault_in    = fault_ff;
      plan.acts   = rss_pkg::act_list(rss_pkg::A_NONE, rss_pkg::A_NONE, rss_pkg::A_NONE,
                                      rss_pkg::A_NONE, rss_pkg::A_NONE);
      plan.count  = 3'd1;
      plan.dur    = '0;

      case (req_data.opcode)
         rss_pkg::OP_START: begin
            if (state_ff != rss_pkg::ST_IDLE) begin
               plan.acts[0] = rss_pkg::A_IGNORED;
            end else if (!cfg.profile_ready) begin
               plan.acts[0] = rss_pkg::A_SECURE;
               plan.acts[1] = rss_pkg::A_PROFILE_REJ;
               plan.count   = 3'd2;
            end else begin
               state_in     = rss_pkg::ST_AUTH;
               plan.acts[0] = rss_pkg::A_REQ_VEHICLE;
               plan.acts[1] = rss_pkg::A_ARM;
               plan.count   = 3'd2;
               plan.dur     = cfg.authorize_timeout_ms;
            end
         end
         rss_pkg::OP_STOP: begin
            case (state_ff)
               rss_pkg::ST_AUTH, rss_pkg::ST_PREP, rss_pkg::ST_CRANK: to_stopped = 1'b1;
               rss_pkg::ST_RUN: to_stopping = 1'b1;
               rss_pkg::ST_FAULT: begin
                  plan.acts[0] = rss_pkg::A_SECURE;
                  plan.acts[1] = rss_pkg::A_IGNORED;
                  plan.count   = 3'd2;
               end
               rss_pkg::ST_IDLE: plan.acts[0] = rss_pkg::A_STOPPED;
               default: plan.acts[0] = rss_pkg::A_IGNORED;
            endcase
         end
         rss_pkg::OP_UPDATE: begin
            case (state_ff)
               rss_pkg::ST_AUTH: begin
                  if (req_data.start_safe) begin
                     state_in   = rss_pkg::ST_PREP;
                     plan.acts  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_IGNITION,
                                    rss_pkg::A_START_ACC, rss_pkg::A_ARM, rss_pkg::A_NONE);
                     plan.count = 3'd4;
                     plan.dur   = cfg.prepare_delay_ms;
                  end else begin
                     state_in   = rss_pkg::ST_IDLE;
                     fault_in   = rss_pkg::F_NONE;
                     plan.acts  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_SECURE,
                                    rss_pkg::A_START_REJ, rss_pkg::A_NONE, rss_pkg::A_NONE);
                     plan.count = 3'd3;
                  end
               end
               rss_pkg::ST_PREP: to_fault = !req_data.start_safe;
               rss_pkg::ST_CRANK: begin
                  if (!req_data.crank_safe) begin
                     to_fault = 1'b1;
                  end else if (eng) begin
                     state_in   = rss_pkg::ST_RUN;
                     plan.acts  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_DISENGAGE,
                                    rss_pkg::A_RUNNING, rss_pkg::A_ARM, rss_pkg::A_NONE);
                     plan.count = 3'd4;
                     plan.dur   = cfg.run_limit_ms;
                  end
               end
               rss_pkg::ST_RUN: to_fault = !req_data.run_safe;
               rss_pkg::ST_STOPPING: to_stopped = rpm_low;
               default: ;
            endcase
         end
         rss_pkg::OP_TIMER: begin
            case (state_ff)
               rss_pkg::ST_AUTH: begin
                  to_fault  = 1'b1;
                  new_fault = rss_pkg::F_AUTH_TIMEOUT;
               end
               rss_pkg::ST_PREP: begin
                  if (req_data.start_safe) begin
                     state_in   = rss_pkg::ST_CRANK;
                     plan.acts  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_ENGAGE,
                                    rss_pkg::A_ARM, rss_pkg::A_NONE, rss_pkg::A_NONE);
                     plan.count = 3'd3;
                     plan.dur   = cfg.crank_limit_ms;
                  end else begin
                     to_fault = 1'b1;
                  end
               end
               rss_pkg::ST_CRANK: begin
                  to_fault  = 1'b1;
                  new_fault = rss_pkg::F_CRANK_TIMEOUT;
               end
               rss_pkg::ST_RUN: to_stopping = 1'b1;
               rss_pkg::ST_STOPPING: begin
                  to_fault  = 1'b1;
                  new_fault = rss_pkg::F_STOP_TIMEOUT;
               end
               default: ;
            endcase
         end
         rss_pkg::OP_INFRA: begin
            to_fault  = 1'b1;
            new_fault = infra_fault;
         end
         rss_pkg::OP_RESET: begin
            if (state_ff != rss_pkg::ST_FAULT) begin
               plan.acts[0] = rss_pkg::A_IGNORED;
            end else if (!rpm_low || !crit_clear) begin
               plan.acts[0] = rss_pkg::A_SECURE;
               plan.acts[1] = rss_pkg::A_RESET_REJ;
               plan.count   = 3'd2;
            end else begin
               state_in   = rss_pkg::ST_IDLE;
               fault_in   = rss_pkg::F_NONE;
               plan.acts  = rss_pkg::act_list(rss_pkg::A_CANCEL, rss_pkg::A_SECURE,
                              rss_pkg::A_READY, rss_pkg::A_NONE, rss_pkg::A_NONE);
               plan.count = 3'd3;
            end
         end
         default: ;
      endcase

      if (to_fault) begin
         state_in   = rss_pkg::ST_FAULT;
         fault_in   = new_fault;
         plan.acts  = fault_seq;
         plan.count = 3'd4;
      end else if (to_stopped) begin
         state_in   = rss_pkg::ST_IDLE;
         fault_in   = rss_pkg::F_NONE;
         plan.acts  = stopped_seq;
         plan.count = 3'd4;
      end else if (to_stopping) begin
         state_in   = rss_pkg::ST_STOPPING;
         plan.acts  = stopping_seq;
         plan.count = 3'd5;
         plan.dur   = cfg.stop_confirm_ms;
      end

      plan.prior = state_ff;
      plan.nxt   = state_in;
      plan.fault = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rss_pkg::ST_IDLE;
         fault_ff <= rss_pkg::F_NONE;
      end else if (push) begin
         state_ff <= state_in;
         fault_ff <= fault_in;
      end
   end

endmodule

[rtl/rss_queue.sv]
// ----------------------------------------------------------------------------
// rss_queue
// two-entry plan queue between the front and the back
// ----------------------------------------------------------------------------
module rss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rss_pkg::plan_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output rss_pkg::plan_type q_data
);

   localparam int PtrW = $clog2(rss_pkg::Q_DEPTH);

   rss_pkg::plan_type mem [rss_pkg::Q_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   used_ff, used_in;

   assign full    = (used_ff == (PtrW+1)'(rss_pkg::Q_DEPTH));
   assign q_valid = (used_ff != '0);
   assign q_data  = mem[rd_ptr_ff];

   always_comb begin
      used_in = used_ff;
      if (push && !pop) begin
         used_in = used_ff + 1'b1;
      end else if (pop && !push) begin
         used_in = used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         used_ff <= used_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/rss_back.sv]
// ----------------------------------------------------------------------------
// rss_back
// walks a plan one action per cycle into the registered response stage while rsp_ready does not stall it
// ----------------------------------------------------------------------------
`include "remote_start_sequencer_assert.svh"

module rss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rss_pkg::plan_type q_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rss_pkg::rsp_type  rsp_data
);

   rss_pkg::plan_type cur_ff;
   logic [rss_pkg::CNT_W-1:0] idx_ff;
   logic busy_ff;
   logic rsp_valid_ff;
   rss_pkg::rsp_type rsp_ff, rsp_in;
   logic adv, emit, last_item;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign emit      = busy_ff && adv;
   assign last_item = (idx_ff == cur_ff.count - 1'b1);
   assign pop       = q_valid && (!busy_ff || (emit && last_item));

   always_comb begin
      rsp_in.action      = cur_ff.acts[idx_ff];
      rsp_in.duration_ms = (cur_ff.acts[idx_ff] == rss_pkg::A_ARM) ? cur_ff.dur : '0;
      rsp_in.prior_state = cur_ff.prior;
      rsp_in.new_state   = cur_ff.nxt;
      rsp_in.fault_now   = cur_ff.fault;
      rsp_in.last        = last_item;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_data;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (emit) begin
            if (last_item) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RSS_ASSERT(a_count_range, clock, reset,
      !busy_ff || (cur_ff.count != '0 && cur_ff.count <= 3'(rss_pkg::MAX_ACTS)))
   `RSS_ASSERT_NEXT(a_pop_restarts, clock, reset, pop, busy_ff && idx_ff == '0)
   `RSS_ASSERT_NEXT(a_mid_plan_busy, clock, reset, emit && !last_item,
      busy_ff && rsp_valid_ff && !rsp_ff.last)

endmodule

[rtl/remote_start_sequencer.sv]
// ----------------------------------------------------------------------------
// remote_start_sequencer
// remote engine start controller: one event in, a run of action items out
// ----------------------------------------------------------------------------
// usage
//  - req channel: one event per request (valid/ready), classified on accept
//  - rsp channel: one action item per transfer; the final item of an event
//    has last set, and every item carries prior state, new state and fault
//  - csr port: apb-style, seven registers at byte address 4*index, pready
//    always high, reads return the stored value zero-extended
//  - first item path: an accepted event's plan passes through the queue,
//    the back plan register and then the output register
//  - throughput: the back emits one item per cycle while rsp_ready does not
//    stall it, and an event carries 1 to 5 items; the front takes a request
//    each cycle while the two-entry plan queue has room
//  - reset (synchronous): state idle, fault none, registers zero, queue and
//    output stage empty
//  - rsp stall: the output register holds its item; the back waits, the
//    queue fills, and then req_ready drops until the back drains a plan
// ----------------------------------------------------------------------------
module remote_start_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rss_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rss_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rss_pkg::ADDR_W-1:0] paddr,
   input  logic [rss_pkg::DATA_W-1:0] pwdata,
   output logic [rss_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   rss_pkg::cfg_type  cfg_ff;
   rss_pkg::plan_type plan, q_data;
   logic push, pop, q_full, q_valid, csr_wr;
   rss_pkg::reg_index_type csr_idx;

   // configuration registers
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = rss_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            rss_pkg::R_AUTH_TIMEOUT: cfg_ff.authorize_timeout_ms <= pwdata[19:0];
            rss_pkg::R_PREP_DELAY:   cfg_ff.prepare_delay_ms     <= pwdata[19:0];
            rss_pkg::R_CRANK_LIMIT:  cfg_ff.crank_limit_ms       <= pwdata[19:0];
            rss_pkg::R_RUN_LIMIT:    cfg_ff.run_limit_ms         <= pwdata[19:0];
            rss_pkg::R_STOP_CONFIRM: cfg_ff.stop_confirm_ms      <= pwdata[19:0];
            rss_pkg::R_RPM_LEVEL:    cfg_ff.running_rpm_level    <= pwdata[13:0];
            rss_pkg::R_PROFILE:      cfg_ff.profile_ready        <= pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux, unmapped addresses read zero
   always_comb begin
      prdata = '0;
      case (csr_idx)
         rss_pkg::R_AUTH_TIMEOUT: prdata = 32'(cfg_ff.authorize_timeout_ms);
         rss_pkg::R_PREP_DELAY:   prdata = 32'(cfg_ff.prepare_delay_ms);
         rss_pkg::R_CRANK_LIMIT:  prdata = 32'(cfg_ff.crank_limit_ms);
         rss_pkg::R_RUN_LIMIT:    prdata = 32'(cfg_ff.run_limit_ms);
         rss_pkg::R_STOP_CONFIRM: prdata = 32'(cfg_ff.stop_confirm_ms);
         rss_pkg::R_RPM_LEVEL:    prdata = 32'(cfg_ff.running_rpm_level);
         rss_pkg::R_PROFILE:      prdata = 32'(cfg_ff.profile_ready);
         default:                 prdata = '0;
      endcase
   end

   // front: classify the request and step the controller state
   rss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .plan      (plan)
   );

   // plan queue decouples request acceptance from item delivery
   rss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (plan),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   // back: one action item per cycle into the output register while rsp_ready does not stall it
   rss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
